// File: design/dq_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the bounded deque.
// No dependencies; every other design file but dq_stream_if imports this package.
package dq_pkg;

	localparam int VAL_W = 32;
	localparam int OP_W  = 3;
	localparam int CNT_W = 5;

	// Capacity after reset
	localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(16);

	// Front and rear values reported for an empty deque
	localparam logic signed [VAL_W-1:0] EMPTY_VALUE = '1;

	typedef enum logic [OP_W-1:0] {
		OP_INS_FRONT = 3'd0,
		OP_INS_BACK  = 3'd1,
		OP_DEL_FRONT = 3'd2,
		OP_DEL_BACK  = 3'd3,
		OP_PEEK      = 3'd4
	} op_e_t;

	// Request beat
	typedef struct packed {
		logic [OP_W-1:0]         op;
		logic signed [VAL_W-1:0] value;
	} dq_req_t;

	// Response beat
	typedef struct packed {
		logic                    ok;
		logic signed [VAL_W-1:0] front_value;
		logic signed [VAL_W-1:0] rear_value;
		logic                    is_empty;
		logic                    is_full;
		logic [CNT_W-1:0]        count;
	} dq_rsp_t;

	// Per-cell control from the top level
	typedef struct packed {
		logic shift_r;  // take left neighbor (insert at front)
		logic shift_l;  // take right neighbor (delete at front)
		logic load;     // take the request value (insert at back)
	} dq_ctrl_t;

endpackage

// File: design/dq_stream_if.sv
`timescale 1ns / 1ps
// Valid/ready stream interface carrying one payload beat.
// Depends on nothing; the payload type is a parameter.
interface dq_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: design/dq_cell.sv
`timescale 1ns / 1ps
// One storage cell of the deque shift chain.
// Depends on dq_pkg for the value width and the control struct.
module dq_cell
	import dq_pkg::*;
(
	input  logic                    clk,
	input  dq_ctrl_t                ctrl,
	input  logic signed [VAL_W-1:0] load_val,
	input  logic signed [VAL_W-1:0] nbr_left,
	input  logic signed [VAL_W-1:0] nbr_right,
	output logic signed [VAL_W-1:0] data,
	output logic signed [VAL_W-1:0] data_nxt
);

	logic signed [VAL_W-1:0] data_q;

	// next content: shift toward rear, shift toward front, load, or hold
	always_comb begin
		if (ctrl.shift_r) begin
			data_nxt = nbr_left;
		end else if (ctrl.shift_l) begin
			data_nxt = nbr_right;
		end else if (ctrl.load) begin
			data_nxt = load_val;
		end else begin
			data_nxt = data_q;
		end
	end

	// payload register, no reset
	always_ff @(posedge clk) begin
		data_q <= data_nxt;
	end

	assign data = data_q;

endmodule

// File: design/bounded_deque_core.sv
`timescale 1ns / 1ps
// Bounded deque built as a row of DEPTH shift cells, front entry in cell 0.
// The response beat appears in the cycle after the request beat is taken.
// Throughput: one request per cycle while rsp is ready; the cell row updates once per beat.
// Reset: count cleared, capacity back to 16, response slot empty; cell contents not reset.
// Depends on dq_pkg, dq_stream_if and dq_cell.
module bounded_deque_core
	import dq_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CNT_W-1:0]    cfg_wdata,
	dq_stream_if.sink           req,
	dq_stream_if.source         rsp
);

	localparam int CAP_MAX = (DEPTH < 31) ? DEPTH : 31;
	localparam logic [CNT_W-1:0] CAP_MAX_C = CNT_W'(CAP_MAX);

	logic [CNT_W-1:0]        cap_q;
	logic [CNT_W-1:0]        count_q;
	logic                    rsp_valid_q;
	dq_rsp_t                 rsp_data_q;

	logic [CNT_W-1:0]        eff_cap;
	logic [CNT_W-1:0]        count_n;
	logic                    accept;
	logic                    full;
	logic                    ok;
	logic                    ins_front;
	logic                    ins_back;
	logic                    del_front;
	logic                    del_back;
	logic signed [VAL_W-1:0] rear_n;

	logic signed [VAL_W-1:0] cur [DEPTH];
	logic signed [VAL_W-1:0] nxt [DEPTH];
	logic signed [VAL_W-1:0] tail_val [DEPTH];

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	// capacity clamped to 1..min(DEPTH, 31)
	always_comb begin
		if (cap_q == '0) begin
			eff_cap = CNT_W'(1);
		end else if (cap_q > CAP_MAX_C) begin
			eff_cap = CAP_MAX_C;
		end else begin
			eff_cap = cap_q;
		end
	end

	assign full = (count_q >= eff_cap);

	// decode the request
	always_comb begin
		ins_front = 1'b0;
		ins_back  = 1'b0;
		del_front = 1'b0;
		del_back  = 1'b0;
		ok        = 1'b1;
		case (op_e_t'(req.data.op))
			OP_INS_FRONT: begin
				ins_front = !full;
				ok        = !full;
			end
			OP_INS_BACK: begin
				ins_back = !full;
				ok       = !full;
			end
			OP_DEL_FRONT: begin
				del_front = (count_q != '0);
				ok        = (count_q != '0);
			end
			OP_DEL_BACK: begin
				del_back = (count_q != '0);
				ok       = (count_q != '0);
			end
			default: begin
				ok = 1'b1;
			end
		endcase
	end

	// entry count after this beat
	always_comb begin
		count_n = count_q;
		if (accept && (ins_front || ins_back)) begin
			count_n = count_q + CNT_W'(1);
		end else if (accept && (del_front || del_back)) begin
			count_n = count_q - CNT_W'(1);
		end
	end

	// cell row
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam int unsigned IDX = i;
		dq_ctrl_t                ctrl;
		logic signed [VAL_W-1:0] left;
		logic signed [VAL_W-1:0] right;

		assign ctrl.shift_r = accept && ins_front;
		assign ctrl.shift_l = accept && del_front;
		assign ctrl.load    = accept && ins_back && (32'(count_q) == IDX);

		if (i == 0) begin : g_first
			assign left = req.data.value;
		end else begin : g_mid_l
			assign left = cur[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right = '0;
		end else begin : g_mid_r
			assign right = cur[i+1];
		end

		dq_cell u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.load_val (req.data.value),
			.nbr_left (left),
			.nbr_right(right),
			.data     (cur[i]),
			.data_nxt (nxt[i])
		);

		// this cell holds the rear entry after the beat
		assign tail_val[i] = (32'(count_n) == IDX + 1) ? nxt[i] : '0;
	end

	// rear value: at most one cell is the tail
	always_comb begin
		rear_n = '0;
		for (int k = 0; k < DEPTH; k++) begin
			rear_n = rear_n | tail_val[k];
		end
	end

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// entry count and response slot valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_n;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_data_q.ok          <= ok;
			rsp_data_q.front_value <= (count_n == '0) ? EMPTY_VALUE : nxt[0];
			rsp_data_q.rear_value  <= (count_n == '0) ? EMPTY_VALUE : rear_n;
			rsp_data_q.is_empty    <= (count_n == '0);
			rsp_data_q.is_full     <= (count_n >= eff_cap);
			rsp_data_q.count       <= count_n;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

endmodule

// File: design/dq_checker.sv
`timescale 1ns / 1ps
// Port-level checks on the deque response stream, bound to bounded_deque_core.
// Depends on dq_pkg for widths and the empty value.
module dq_checker
	import dq_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    rsp_valid,
	input logic                    rsp_ready,
	input logic                    ok,
	input logic signed [VAL_W-1:0] front_value,
	input logic signed [VAL_W-1:0] rear_value,
	input logic                    is_empty,
	input logic                    is_full,
	input logic [CNT_W-1:0]        count
);

	// empty flag matches count and both ends read as the empty value
	a_empty_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (is_empty == (count == '0)) &&
			(!is_empty || (front_value == EMPTY_VALUE && rear_value == EMPTY_VALUE)))
		else $error("empty flag, count and end values disagree");

	// a single entry is both front and rear
	a_single_entry: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && count == CNT_W'(1) |-> front_value == rear_value)
		else $error("single entry shows different front and rear");

	// a refused request is only possible on a full or an empty deque
	a_refused_reason: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !ok |-> is_full || is_empty)
		else $error("request refused with room and entries available");

	// a stalled response beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(count) &&
			$stable(front_value) && $stable(rear_value) && $stable(ok))
		else $error("stalled response beat changed");

endmodule

bind bounded_deque_core dq_checker u_dq_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.ok         (rsp.data.ok),
	.front_value(rsp.data.front_value),
	.rear_value (rsp.data.rear_value),
	.is_empty   (rsp.data.is_empty),
	.is_full    (rsp.data.is_full),
	.count      (rsp.data.count)
);

// File: verif/bounded_deque_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for bounded_deque_core: random and directed deque ops
// checked beat by beat against an in-bench deque tracker.
// Depends on dq_pkg, dq_stream_if and the design files.
module bounded_deque_core_tb;
	import dq_pkg::*;

	localparam int DEPTH = 16;
	localparam int IDX_W = $clog2(DEPTH);
	localparam logic [OP_W-1:0] OP_CODE_MAX = '1;  // highest op encoding, 5..7 act as peek

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CNT_W-1:0] cfg_wdata;

	dq_stream_if #(.T(dq_req_t)) req_if ();
	dq_stream_if #(.T(dq_rsp_t)) rsp_if ();

	bounded_deque_core #(.DEPTH(DEPTH)) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req      (req_if),
		.rsp      (rsp_if)
	);

	// 100 MHz clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Tracked deque contents and settings
	logic signed [VAL_W-1:0] cells [DEPTH];
	logic [IDX_W-1:0] head;
	logic [CNT_W-1:0] held;
	logic [CNT_W-1:0] cap_shadow;

	dq_req_t req_backlog [$];
	dq_rsp_t status_due [$];

	int send_idle_pct;
	int stall_pct;
	int mismatches;
	logic req_fire;

	// Apply one request to the tracked deque and return the status it should report
	function automatic dq_rsp_t deque_apply(dq_req_t beat);
		dq_rsp_t st;
		logic [CNT_W-1:0] lim;
		logic full;
		logic ok;
		lim = (cap_shadow == '0) ? CNT_W'(1) :
			(cap_shadow > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : cap_shadow;
		full = held >= lim;
		ok = 1'b1;
		case (beat.op)
			OP_INS_FRONT, OP_INS_BACK: begin
				if (full) begin
					ok = 1'b0;
				end else begin
					if (beat.op == OP_INS_FRONT) begin
						head = head - 1'b1;
						cells[head] = beat.value;
					end else begin
						cells[head + IDX_W'(held)] = beat.value;
					end
					held = held + 1'b1;
				end
			end
			OP_DEL_FRONT, OP_DEL_BACK: begin
				if (held == '0) begin
					ok = 1'b0;
				end else begin
					if (beat.op == OP_DEL_FRONT)
						head = head + 1'b1;
					held = held - 1'b1;
				end
			end
			default: ;  // peek and unused codes leave the deque alone
		endcase
		st.ok = ok;
		st.front_value = EMPTY_VALUE;
		st.rear_value = EMPTY_VALUE;
		if (held != '0) begin
			st.front_value = cells[head];
			st.rear_value = cells[head + IDX_W'(held - 1'b1)];
		end
		st.is_empty = (held == '0);
		st.is_full = (held >= lim);
		st.count = held;
		return st;
	endfunction

	task automatic report_field(string name, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	// Monitor: check response beats, then track accepted request beats
	always @(posedge clk) begin
		dq_rsp_t want;
		dq_rsp_t got;
		req_fire <= req_if.valid && req_if.ready;
		if (arst_n) begin
			if (rsp_if.valid && rsp_if.ready) begin
				got = rsp_if.data;
				if (status_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: response beat with nothing outstanding", $time);
				end else begin
					want = status_due.pop_front();
					report_field("ok", VAL_W'(want.ok), VAL_W'(got.ok));
					report_field("front_value", want.front_value, got.front_value);
					report_field("rear_value", want.rear_value, got.rear_value);
					report_field("is_empty", VAL_W'(want.is_empty), VAL_W'(got.is_empty));
					report_field("is_full", VAL_W'(want.is_full), VAL_W'(got.is_full));
					report_field("count", VAL_W'(want.count), VAL_W'(got.count));
				end
			end
			if (req_if.valid && req_if.ready)
				status_due = {status_due, deque_apply(req_if.data)};
		end
	end

	// Request driver: next beat once the current one is taken, with random gaps
	always @(negedge clk) begin
		if (!req_if.valid || req_fire) begin
			if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				req_if.data <= req_backlog.pop_front();
				req_if.valid <= 1'b1;
			end else begin
				req_if.valid <= 1'b0;
			end
		end
	end

	// Response sink with random back-pressure
	always @(negedge clk)
		rsp_if.ready <= ($urandom_range(99) >= stall_pct);

	function automatic logic signed [VAL_W-1:0] pick_value();
		case ($urandom_range(7))
			0: return {1'b0, {(VAL_W-1){1'b1}}};
			1: return {1'b1, {(VAL_W-1){1'b0}}};
			2: return '1;
			3: return VAL_W'($urandom_range(15));
			default: return $urandom;
		endcase
	endfunction

	task automatic queue_req(logic [OP_W-1:0] op, logic signed [VAL_W-1:0] value);
		dq_req_t beat;
		beat.op = op;
		beat.value = value;
		req_backlog = {req_backlog, beat};
	endtask

	// Wait until every beat is through and the core has settled
	task automatic drain();
		while (req_backlog.size() != 0 || req_if.valid || status_due.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_capacity(logic [CNT_W-1:0] cap);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = cap;
		cap_shadow = cap;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// One setting of capacity, idling and back-pressure, then a random run biased by ins_pct
	task automatic run_phase(logic [CNT_W-1:0] cap, int send_pct, int rsp_pct, int n,
			int ins_pct);
		int r;
		write_capacity(cap);
		send_idle_pct = send_pct;
		stall_pct = rsp_pct;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < ins_pct)
				queue_req($urandom_range(1) ? OP_INS_BACK : OP_INS_FRONT, pick_value());
			else if (r < 94)
				queue_req($urandom_range(1) ? OP_DEL_BACK : OP_DEL_FRONT, pick_value());
			else
				queue_req(OP_W'($urandom_range(OP_PEEK, OP_CODE_MAX)), pick_value());
		end
		drain();
	endtask

	// Stimulus sequence
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_if.valid = 1'b0;
		req_if.data = '0;
		rsp_if.ready = 1'b0;
		req_fire = 1'b0;
		send_idle_pct = 0;
		stall_pct = 0;
		mismatches = 0;
		head = '0;
		held = '0;
		cap_shadow = CAP_RESET;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty refusals, unused codes, extreme values, both ends
		queue_req(OP_PEEK, '0);
		queue_req(OP_DEL_FRONT, '1);
		queue_req(OP_DEL_BACK, '1);
		queue_req(OP_W'(OP_PEEK + 1), '1);
		queue_req(OP_CODE_MAX, '1);
		queue_req(OP_INS_FRONT, {1'b0, {(VAL_W-1){1'b1}}});
		queue_req(OP_INS_BACK, {1'b1, {(VAL_W-1){1'b0}}});
		queue_req(OP_INS_FRONT, '1);
		queue_req(OP_INS_BACK, '0);
		queue_req(OP_PEEK, 32'h5a5a_a5a5);
		queue_req(OP_DEL_BACK, '0);
		queue_req(OP_DEL_FRONT, '0);
		queue_req(OP_DEL_FRONT, '0);
		queue_req(OP_DEL_BACK, '0);
		queue_req(OP_DEL_BACK, '0);
		drain();

		// Capacity one: insert on full refused
		write_capacity(CNT_W'(1));
		queue_req(OP_INS_BACK, 32'h1234_5678);
		queue_req(OP_INS_FRONT, 32'h0bad_cafe);
		queue_req(OP_PEEK, '0);
		queue_req(OP_DEL_FRONT, '0);
		drain();

		run_phase('0, 0, 0, 40, 50);                            // zero taken as one
		run_phase('1, 59, 0, 120, 70);                          // above depth, fills up
		run_phase(CNT_W'(2), 0, 59, 80, 40);                    // lowered below count
		run_phase(CNT_W'(DEPTH), 18, 18, 120, 55);
		run_phase(CNT_W'($urandom_range(DEPTH + 1, 31)), 0, 0, 80, 60);
		run_phase(CNT_W'(5), 59, 0, 80, 50);
		run_phase(CNT_W'(1), 0, 59, 60, 50);
		run_phase(CNT_W'($urandom_range(1, DEPTH)), 18, 18, 60, 50);

		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// Hang guard
	initial begin
		#5ms;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: filelist.f
design/dq_pkg.sv
design/dq_stream_if.sv
design/dq_cell.sv
design/bounded_deque_core.sv
design/dq_checker.sv
verif/bounded_deque_core_tb.sv
